### rtl/core/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types, codes and defaults of the LSB-first bit packer.
// ----------------------------------------------------------------------------
package lbp_pkg;

    localparam int MAX_PUSH_BITS_DEF = 32;
    localparam int BYTE_W            = 8;
    localparam int IN_BITS_W         = 32;
    localparam int NUM_BITS_W        = 6;
    localparam int COUNT_W           = 16;
    localparam int STATUS_W          = 2;
    localparam int CMD_W             = 2;

    localparam logic [COUNT_W-1:0] CAP_RESET = 16'd4096;

    localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FLUSH   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ALIGNED = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_COUNT = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic                byte_valid;
        logic                last;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  byte_count;
    } t_result;

endpackage

### rtl/core/lbp_out_stage.sv
// ----------------------------------------------------------------------------
// lbp_out_stage
// Output register of the bit packer: holds one result beat until it is taken.
// ----------------------------------------------------------------------------
module lbp_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  lbp_pkg::t_result i_res,
    input  logic             i_stall,
    output logic             o_valid,
    output lbp_pkg::t_result o_res,
    output logic             o_free
);

    logic             r_valid;
    logic             n_valid;
    lbp_pkg::t_result r_res;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_free) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("result loaded over an untaken beat");

    a_held_beat_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_stall |=> r_valid && $stable(r_res))
        else $error("stalled result beat changed");

    a_no_bad_status_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_res.last |-> r_res.byte_valid && r_res.status == lbp_pkg::STAT_OK)
        else $error("non-final beat without a byte or with a status");

endmodule

### rtl/core/lsb_first_bit_packer.sv
// ----------------------------------------------------------------------------
// lsb_first_bit_packer
// Packs bit fields LSB first into bytes; one byte-wide shift step per emitted byte.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                 Payload
//  in       input      i_in_valid / o_in_stall   i_cmd, i_bits, i_num_bits
//  out      output     o_out_valid / i_out_stall o_out_byte, o_byte_valid, o_last,
//                                                o_status, o_byte_count
//  cfg      input      i_cfg_valid / o_cfg_ready i_cfg_data (capacity in bytes)
//
//  An accepted item is loaded into the accumulator, then the byte shift step
//  emits its result beats in order, the final one marked last.
//  Output stalls hold the sequencer; the input is stalled while an item runs.
//  Reset is synchronous: pending bits and byte count clear, capacity is 4096.
// ----------------------------------------------------------------------------
module lsb_first_bit_packer #(
    parameter int MAX_PUSH_BITS = lbp_pkg::MAX_PUSH_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [lbp_pkg::CMD_W-1:0]       i_cmd,
    input  logic [lbp_pkg::IN_BITS_W-1:0]   i_bits,
    input  logic [lbp_pkg::NUM_BITS_W-1:0]  i_num_bits,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [lbp_pkg::BYTE_W-1:0]      o_out_byte,
    output logic                            o_byte_valid,
    output logic                            o_last,
    output logic [lbp_pkg::STATUS_W-1:0]    o_status,
    output logic [lbp_pkg::COUNT_W-1:0]     o_byte_count,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lbp_pkg::COUNT_W-1:0]     i_cfg_data
);

    localparam int BW   = lbp_pkg::BYTE_W;
    localparam int AccW = MAX_PUSH_BITS + BW;
    localparam int RemW = $clog2(AccW + 1);
    localparam int ExtW = (MAX_PUSH_BITS > lbp_pkg::IN_BITS_W) ?
                          MAX_PUSH_BITS : lbp_pkg::IN_BITS_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic                                r_state;
    logic                                n_state;
    logic [BW-2:0]                       r_pend;
    logic [BW-2:0]                       n_pend;
    logic [2:0]                          r_pcnt;
    logic [2:0]                          n_pcnt;
    logic [lbp_pkg::COUNT_W-1:0]         r_held;
    logic [lbp_pkg::COUNT_W-1:0]         n_held;
    logic [lbp_pkg::COUNT_W-1:0]         r_cap;
    logic [AccW-1:0]                     r_acc;
    logic [AccW-1:0]                     n_acc;
    logic [RemW-1:0]                     r_rem;
    logic [RemW-1:0]                     n_rem;
    logic                                r_flush;
    logic                                n_flush;
    logic [lbp_pkg::STATUS_W-1:0]        r_status;
    logic [lbp_pkg::STATUS_W-1:0]        n_status;

    logic                                in_accept;
    logic                                out_free;
    logic                                out_load;
    lbp_pkg::t_result                    res;
    lbp_pkg::t_result                    out_res;
    logic [ExtW-1:0]                     bits_ext;
    logic [MAX_PUSH_BITS-1:0]            masked;
    logic [AccW-1:0]                     acc_shift;
    logic [RemW-1:0]                     rem_sub;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_load    = (r_state == S_RUN) && out_free;
    assign bits_ext    = ExtW'(i_bits);
    assign acc_shift   = r_acc >> BW;
    assign rem_sub     = r_rem - RemW'(BW);

    always_comb begin
        for (int i = 0; i < MAX_PUSH_BITS; i++) begin
            masked[i] = bits_ext[i] && (i < int'(i_num_bits));
        end
    end

    always_comb begin
        n_state  = r_state;
        n_pend   = r_pend;
        n_pcnt   = r_pcnt;
        n_held   = r_held;
        n_acc    = r_acc;
        n_rem    = r_rem;
        n_flush  = r_flush;
        n_status = r_status;
        res      = '0;

        if (in_accept) begin
            n_state  = S_RUN;
            n_flush  = 1'b0;
            n_status = lbp_pkg::STAT_OK;
            n_acc    = AccW'(r_pend);
            n_rem    = RemW'(r_pcnt);
            case (i_cmd)
                lbp_pkg::CMD_PUSH: begin
                    if (int'(i_num_bits) > MAX_PUSH_BITS) begin
                        n_status = lbp_pkg::STAT_BAD_COUNT;
                    end else begin
                        n_acc = (AccW'(masked) << r_pcnt) | AccW'(r_pend);
                        n_rem = RemW'(r_pcnt) + RemW'(i_num_bits);
                    end
                end
                lbp_pkg::CMD_FLUSH: begin
                    if (r_pcnt != 3'd0) begin
                        n_rem   = RemW'(BW);
                        n_flush = 1'b1;
                    end
                end
                lbp_pkg::CMD_ALIGNED: begin
                    if (r_pcnt != 3'd0) begin
                        n_acc   = (AccW'(i_bits[BW-1:0]) << BW) | AccW'(r_pend);
                        n_rem   = RemW'(2 * BW);
                        n_flush = 1'b1;
                    end else begin
                        n_acc = AccW'(i_bits[BW-1:0]);
                        n_rem = RemW'(BW);
                    end
                end
                default: begin
                    n_held = '0;
                end
            endcase
        end else if (out_load) begin
            n_flush = 1'b0;
            if (r_rem >= RemW'(BW)) begin
                if (r_held < r_cap) begin
                    n_held         = r_held + 1'b1;
                    n_acc          = acc_shift;
                    n_rem          = rem_sub;
                    res.out_byte   = r_acc[BW-1:0];
                    res.byte_valid = 1'b1;
                    res.last       = (rem_sub < RemW'(BW));
                    res.status     = lbp_pkg::STAT_OK;
                    res.byte_count = r_held + 1'b1;
                    if (rem_sub < RemW'(BW)) begin
                        n_state = S_IDLE;
                        n_pend  = acc_shift[BW-2:0];
                        n_pcnt  = rem_sub[2:0];
                    end
                end else begin
                    res.last       = 1'b1;
                    res.status     = lbp_pkg::STAT_OVERFLOW;
                    res.byte_count = r_held;
                    n_state        = S_IDLE;
                    if (!r_flush) begin
                        n_pend = '0;
                        n_pcnt = '0;
                    end
                end
            end else begin
                res.last       = 1'b1;
                res.status     = r_status;
                res.byte_count = r_held;
                n_state        = S_IDLE;
                n_pend         = r_acc[BW-2:0];
                n_pcnt         = r_rem[2:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= '0;
            r_pcnt  <= '0;
            r_held  <= '0;
            r_cap   <= lbp_pkg::CAP_RESET;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_pcnt  <= n_pcnt;
            r_held  <= n_held;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_rem    <= n_rem;
        r_flush  <= n_flush;
        r_status <= n_status;
    end

    lbp_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_res   (res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_res   (out_res),
        .o_free  (out_free)
    );

    assign o_out_byte   = out_res.out_byte;
    assign o_byte_valid = out_res.byte_valid;
    assign o_last       = out_res.last;
    assign o_status     = out_res.status;
    assign o_byte_count = out_res.byte_count;

    a_pend_upper_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (AccW'(r_pend) >> r_pcnt) == '0)
        else $error("pending bits above the pending count are set");

    a_accept_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state == S_RUN)
        else $error("accepted beat did not start the sequencer");

    a_count_steps_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && res.byte_valid |=> r_held == $past(r_held) + 1'b1)
        else $error("byte count did not follow an emitted byte");

    a_final_leaves_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && res.last |=> r_state == S_IDLE)
        else $error("sequencer kept running after the final beat");

endmodule

### sim/lsb_first_bit_packer_test.sv
// ----------------------------------------------------------------------------
// lsb_first_bit_packer_test
// Self-checking testbench for the LSB-first bit packer. A directed table walks
// the command set, bad bit counts, overflow on push and on flush, and the
// capacity extremes. Random commands follow in three idling phases, each with
// its own capacity. Every output beat is compared with a local bit-packing
// model, or for a typed directed row with that row's expected final beat.
// ----------------------------------------------------------------------------
module lsb_first_bit_packer_test;

    localparam int CMD_W             = lbp_pkg::CMD_W;
    localparam int STATUS_W          = lbp_pkg::STATUS_W;
    localparam int COUNT_W           = lbp_pkg::COUNT_W;
    localparam int IN_BITS_W         = lbp_pkg::IN_BITS_W;
    localparam int NUM_BITS_W        = lbp_pkg::NUM_BITS_W;
    localparam int BYTE_W            = lbp_pkg::BYTE_W;
    localparam int MAX_PUSH_BITS_DEF = lbp_pkg::MAX_PUSH_BITS_DEF;

    localparam logic [COUNT_W-1:0] CAP_RESET = lbp_pkg::CAP_RESET;

    localparam logic [CMD_W-1:0] CMD_PUSH    = lbp_pkg::CMD_PUSH;
    localparam logic [CMD_W-1:0] CMD_FLUSH   = lbp_pkg::CMD_FLUSH;
    localparam logic [CMD_W-1:0] CMD_ALIGNED = lbp_pkg::CMD_ALIGNED;
    localparam logic [CMD_W-1:0] CMD_RELEASE = lbp_pkg::CMD_RELEASE;

    localparam logic [STATUS_W-1:0] STAT_OK        = lbp_pkg::STAT_OK;
    localparam logic [STATUS_W-1:0] STAT_BAD_COUNT = lbp_pkg::STAT_BAD_COUNT;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = lbp_pkg::STAT_OVERFLOW;

    typedef lbp_pkg::t_result t_result;

    localparam int  N_DIRECTED     = 29;
    localparam int  ITEMS_PER_PASS = 25;
    localparam int  SETTLE_CYCLES  = 8;
    localparam int  LONG_HOLD      = 80;
    localparam int  WATCHDOG_LIMIT = 3000;
    localparam int  MAX_REPORTS    = 10;
    localparam bit  ROW_ITEM       = 1'b0;
    localparam bit  ROW_CAPACITY   = 1'b1;

    typedef struct packed {
        bit                  kind;
        logic [CMD_W-1:0]    cmd;
        logic [31:0]         bits;
        logic [5:0]          nbits;
        bit                  typed;
        logic [STATUS_W-1:0] want_status;
        logic [COUNT_W-1:0]  want_count;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [CMD_W-1:0]       i_cmd;
    logic [IN_BITS_W-1:0]   i_bits;
    logic [NUM_BITS_W-1:0]  i_num_bits;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [BYTE_W-1:0]      o_out_byte;
    logic                   o_byte_valid;
    logic                   o_last;
    logic [STATUS_W-1:0]    o_status;
    logic [COUNT_W-1:0]     o_byte_count;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [COUNT_W-1:0]     i_cfg_data;

    // Side-band copy of the typed expectation, driven together with each item.
    bit                     drv_typed;
    logic [STATUS_W-1:0]    drv_want_status;
    logic [COUNT_W-1:0]     drv_want_count;

    logic [6:0]             pend_bits = '0;
    logic [2:0]             pend_cnt  = '0;
    logic [COUNT_W-1:0]     held      = '0;
    logic [COUNT_W-1:0]     capacity  = CAP_RESET;

    t_result                item_beats[$];
    t_result                pending_beats[$];

    int                     tx_idle_pct;
    int                     rx_idle_pct;
    bit                     hold_request;
    int                     hold_left;
    int                     idle_cycles;
    int                     mismatches;
    int                     items_accepted;
    int                     beats_checked;
    int                     overflow_beats;
    int                     bad_count_beats;
    int                     capacity_writes;

    t_row directed_rows [N_DIRECTED] = '{
        '{ROW_ITEM, CMD_PUSH, 32'h0000_0000, 6'd0, 1'b1, STAT_OK, 16'd0},
        '{ROW_ITEM, CMD_PUSH, 32'hFFFF_FFFF, 6'd33, 1'b1, STAT_BAD_COUNT, 16'd0},
        '{ROW_ITEM, CMD_PUSH, 32'hFFFF_FFFF, 6'd63, 1'b1, STAT_BAD_COUNT, 16'd0},
        '{ROW_ITEM, CMD_PUSH, 32'hFFFF_FFFF, 6'd32, 1'b0, STAT_OK, 16'd0},
        '{ROW_ITEM, CMD_PUSH, 32'h0000_0005, 6'd3, 1'b0, STAT_OK, 16'd0},
        '{ROW_ITEM, CMD_PUSH, 32'h0000_007F, 6'd7, 1'b0, STAT_OK, 16'd0},
        '{ROW_ITEM, CMD_FLUSH, 32'h0000_0000, 6'd0, 1'b0, STAT_OK, 16'd0},
        '{ROW_ITEM, CMD_FLUSH, 32'h0000_0000, 6'd0, 1'b0, STAT_OK, 16'd0},
        '{ROW_ITEM, CMD_ALIGNED, 32'h0000_00A5, 6'd0, 1'b0, STAT_OK, 16'd0},
        '{ROW_ITEM, CMD_PUSH, 32'h0000_0001, 6'd1, 1'b0, STAT_OK, 16'd0},
        '{ROW_ITEM, CMD_ALIGNED, 32'hFFFF_FF3C, 6'd0, 1'b0, STAT_OK, 16'd0},
        '{ROW_ITEM, CMD_RELEASE, 32'h0000_0000, 6'd0, 1'b1, STAT_OK, 16'd0},
        '{ROW_ITEM, CMD_PUSH, 32'h8000_0001, 6'd31, 1'b0, STAT_OK, 16'd0},
        '{ROW_ITEM, CMD_PUSH, 32'hAAAA_AAAA, 6'd32, 1'b0, STAT_OK, 16'd0},
        '{ROW_CAPACITY, CMD_PUSH, 32'd1, 6'd0, 1'b0, STAT_OK, 16'd0},
        '{ROW_ITEM, CMD_RELEASE, 32'h0000_0000, 6'd0, 1'b1, STAT_OK, 16'd0},
        '{ROW_ITEM, CMD_PUSH, 32'h0000_FFFF, 6'd16, 1'b0, STAT_OK, 16'd0},
        '{ROW_ITEM, CMD_PUSH, 32'h0000_0009, 6'd4, 1'b0, STAT_OK, 16'd0},
        '{ROW_ITEM, CMD_FLUSH, 32'h0000_0000, 6'd0, 1'b0, STAT_OK, 16'd0},
        '{ROW_ITEM, CMD_ALIGNED, 32'h0000_0055, 6'd0, 1'b0, STAT_OK, 16'd0},
        '{ROW_ITEM, CMD_RELEASE, 32'h0000_0000, 6'd0, 1'b1, STAT_OK, 16'd0},
        '{ROW_ITEM, CMD_ALIGNED, 32'h0000_00C3, 6'd0, 1'b0, STAT_OK, 16'd0},
        '{ROW_CAPACITY, CMD_PUSH, 32'd0, 6'd0, 1'b0, STAT_OK, 16'd0},
        '{ROW_ITEM, CMD_RELEASE, 32'h0000_0000, 6'd0, 1'b1, STAT_OK, 16'd0},
        '{ROW_ITEM, CMD_PUSH, 32'h0000_00FF, 6'd8, 1'b1, STAT_OVERFLOW, 16'd0},
        '{ROW_ITEM, CMD_FLUSH, 32'h0000_0000, 6'd0, 1'b1, STAT_OK, 16'd0},
        '{ROW_CAPACITY, CMD_PUSH, 32'd65535, 6'd0, 1'b0, STAT_OK, 16'd0},
        '{ROW_ITEM, CMD_PUSH, 32'h0000_0000, 6'd32, 1'b0, STAT_OK, 16'd0},
        '{ROW_ITEM, CMD_FLUSH, 32'h0000_0000, 6'd0, 1'b0, STAT_OK, 16'd0}
    };

    lsb_first_bit_packer u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_bits       (i_bits),
        .i_num_bits   (i_num_bits),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_last       (o_last),
        .o_status     (o_status),
        .o_byte_count (o_byte_count),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic bit take_byte(input logic [7:0] value);
        t_result beat;
        if (held >= capacity) return 1'b0;
        held = held + 16'd1;
        beat = '0;
        beat.out_byte   = value;
        beat.byte_valid = 1'b1;
        beat.byte_count = held;
        item_beats.push_back(beat);
        return 1'b1;
    endfunction

    function automatic logic [STATUS_W-1:0] flush_partial();
        if (pend_cnt == 3'd0) return STAT_OK;
        if (!take_byte({1'b0, pend_bits})) return STAT_OVERFLOW;
        pend_bits = '0;
        pend_cnt  = '0;
        return STAT_OK;
    endfunction

    function automatic logic [STATUS_W-1:0] shift_in(input logic [31:0] value, input int count);
        logic [7:0] acc;
        int         fill;
        acc  = {1'b0, pend_bits};
        fill = pend_cnt;
        for (int i = 0; i < count; i++) begin
            acc  = acc | (8'(value[i]) << fill);
            fill = fill + 1;
            if (fill == 8) begin
                if (!take_byte(acc)) begin
                    pend_bits = '0;
                    pend_cnt  = '0;
                    return STAT_OVERFLOW;
                end
                acc  = '0;
                fill = 0;
            end
        end
        pend_bits = acc[6:0];
        pend_cnt  = fill[2:0];
        return STAT_OK;
    endfunction

    // Fills item_beats with the beats one command produces.
    function automatic void pack_command(input logic [CMD_W-1:0] cmd, input logic [31:0] bits,
                                         input logic [5:0] nbits);
        logic [STATUS_W-1:0] status;
        t_result             beat;
        status = STAT_OK;
        item_beats.delete();
        case (cmd)
            CMD_PUSH: begin
                if (nbits > MAX_PUSH_BITS_DEF) status = STAT_BAD_COUNT;
                else status = shift_in(bits, int'(nbits));
            end
            CMD_FLUSH: begin
                status = flush_partial();
            end
            CMD_ALIGNED: begin
                status = flush_partial();
                if (status == STAT_OK) status = shift_in({24'd0, bits[7:0]}, 8);
            end
            default: begin
                held = '0;
            end
        endcase
        if (status == STAT_OK && item_beats.size() > 0) begin
            beat = item_beats.pop_back();
            beat.last       = 1'b1;
            beat.byte_count = held;
            item_beats.push_back(beat);
        end else begin
            beat = '0;
            beat.last       = 1'b1;
            beat.status     = status;
            beat.byte_count = held;
            item_beats.push_back(beat);
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = '{o_out_byte, o_byte_valid, o_last, o_status, o_byte_count};
                beats_checked++;
                if (got.last && got.status == STAT_OVERFLOW) overflow_beats++;
                if (got.last && got.status == STAT_BAD_COUNT) bad_count_beats++;
                if (pending_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected beat byte=%h bv=%b last=%b st=%0d cnt=%0d",
                                 $time, got.out_byte, got.byte_valid, got.last, got.status,
                                 got.byte_count);
                end else begin
                    want = pending_beats.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: beat mismatch exp byte=%h bv=%b last=%b st=%0d cnt=%0d, got byte=%h bv=%b last=%b st=%0d cnt=%0d",
                                     $time, want.out_byte, want.byte_valid, want.last,
                                     want.status, want.byte_count, got.out_byte,
                                     got.byte_valid, got.last, got.status, got.byte_count);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                capacity = i_cfg_data;
                capacity_writes++;
            end
            if (i_in_valid && !o_in_stall) begin
                items_accepted++;
                pack_command(i_cmd, i_bits, i_num_bits);
                if (drv_typed) begin
                    want = '0;
                    want.last       = 1'b1;
                    want.status     = drv_want_status;
                    want.byte_count = drv_want_count;
                    pending_beats.push_back(want);
                end else begin
                    foreach (item_beats[k]) pending_beats.push_back(item_beats[k]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("** lsb_first_bit_packer: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [31:0] bits,
                                input logic [5:0] nbits, input bit typed,
                                input logic [STATUS_W-1:0] want_status,
                                input logic [COUNT_W-1:0] want_count);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_cmd           <= cmd;
        i_bits          <= bits;
        i_num_bits      <= nbits;
        drv_typed       <= typed;
        drv_want_status <= want_status;
        drv_want_count  <= want_count;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [COUNT_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random_command();
        logic [CMD_W-1:0] cmd;
        logic [5:0]       nbits;
        int               pick;
        pick = $urandom_range(99);
        if (pick < 55) cmd = CMD_PUSH;
        else if (pick < 70) cmd = CMD_FLUSH;
        else if (pick < 85) cmd = CMD_ALIGNED;
        else cmd = CMD_RELEASE;
        if ($urandom_range(99) < 12) nbits = 6'($urandom_range(63, 33));
        else nbits = 6'($urandom_range(32, 0));
        send_command(cmd, $urandom, nbits, 1'b0, STAT_OK, '0);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_cmd           = CMD_PUSH;
        i_bits          = '0;
        i_num_bits      = '0;
        i_out_stall     = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        drv_typed       = 1'b0;
        drv_want_status = STAT_OK;
        drv_want_count  = '0;
        tx_idle_pct     = 14;
        rx_idle_pct     = 55;
        hold_request    = 1'b0;
        hold_left       = 0;
        idle_cycles     = 0;
        mismatches      = 0;
        items_accepted  = 0;
        beats_checked   = 0;
        overflow_beats  = 0;
        bad_count_beats = 0;
        capacity_writes = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CAPACITY) begin
                wait_drained();
                write_capacity(directed_rows[r].bits[COUNT_W-1:0]);
            end else begin
                send_command(directed_rows[r].cmd, directed_rows[r].bits,
                             directed_rows[r].nbits, directed_rows[r].typed,
                             directed_rows[r].want_status, directed_rows[r].want_count);
            end
        end

        for (int pass = 0; pass < 3; pass++) begin
            wait_drained();
            case (pass)
                0: begin
                    tx_idle_pct = 14;
                    rx_idle_pct = 55;
                    write_capacity(16'($urandom_range(4096, 200)));
                end
                1: begin
                    tx_idle_pct = 55;
                    rx_idle_pct = 14;
                    write_capacity(16'($urandom_range(12, 1)));
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    write_capacity(CAP_RESET);
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PASS; n++) begin
                if (pass == 2 && n == 6) hold_request = 1'b1;
                send_random_command();
            end
        end
        wait_drained();

        mismatches = mismatches + pending_beats.size();
        $display("Covered %0d commands and %0d output beats over %0d capacity settings.",
                 items_accepted, beats_checked, capacity_writes);
        $display("Overflow reports: %0d, bad bit count reports: %0d, mismatches: %0d.",
                 overflow_beats, bad_count_beats, mismatches);
        if (mismatches == 0) begin
            $display("** lsb_first_bit_packer: PASSED **");
        end else begin
            $display("** lsb_first_bit_packer: FAILED **");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/lbp_pkg.sv
rtl/core/lbp_out_stage.sv
rtl/core/lsb_first_bit_packer.sv
sim/lsb_first_bit_packer_test.sv
